@@ design/u8seq_pkg.sv @@
// Shared types and constants for the UTF-8 character sequence search.
package u8seq_pkg;

	localparam int CHAR_W = 35;           // 3-bit byte count, 32 bits of bytes
	localparam logic [7:0] CR_BYTE   = 8'd13;
	localparam logic [7:0] MASK_1B   = 8'b1000_0000;
	localparam logic [7:0] MASK_2B   = 8'b1110_0000;
	localparam logic [7:0] LEAD_2B   = 8'b1100_0000;
	localparam logic [7:0] MASK_3B   = 8'b1111_0000;
	localparam logic [7:0] LEAD_3B   = 8'b1110_0000;
	localparam logic [7:0] MASK_4B   = 8'b1111_1000;
	localparam logic [7:0] LEAD_4B   = 8'b1111_0000;

	typedef logic [CHAR_W-1:0] char_t;

	typedef enum logic [1:0] {
		MODE_PAT   = 2'd0,
		MODE_TEXT  = 2'd1,
		MODE_END   = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		K_MATCH     = 3'd0,
		K_FOUND     = 3'd1,
		K_NOT_FOUND = 3'd2,
		K_BAD_LEAD  = 3'd3,
		K_EMPTY     = 3'd4,
		K_TRUNC     = 3'd5,
		K_TOO_LONG  = 3'd6
	} kind_t;

	// Work orders from the front end to the back end
	typedef enum logic [2:0] {
		OP_PAT    = 3'd0,   // append pattern character
		OP_TEXT   = 3'd1,   // shift text character into window and compare
		OP_JUDGE  = 3'd2,   // end of text: report found / not found, clear text
		OP_END    = 3'd3,   // end of text: clear text, report kind if flagged
		OP_CLEAR  = 3'd4,   // drop pattern and text
		OP_REPORT = 3'd5    // report kind only
	} op_t;

	typedef struct packed {
		op_t   op;
		logic  report;
		kind_t kind;
		char_t ch;
	} entry_t;

endpackage

@@ design/u8seq_front.sv @@
// Front end: byte to character assembly, error checks and order classification.
module u8seq_front #(
	parameter int MAX_PATTERN_CHARS = 8,
	parameter int POSITION_BITS     = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [1:0]              mode,
	input  logic [7:0]              byte_value,
	output logic                    push,
	output u8seq_pkg::entry_t       entry,
	output logic [POSITION_BITS:0]  entry_cidx
);
	import u8seq_pkg::*;

	localparam int PLW = $clog2(MAX_PATTERN_CHARS + 1);

	logic [1:0]             br_q, br_n;
	logic                   in_text_q, in_text_n;
	char_t                  partial_q, partial_n;
	logic [PLW-1:0]         plen_q, plen_n;
	logic [POSITION_BITS:0] cidx_q, cidx_n;
	logic                   err_q, err_n;

	logic [2:0] lead_len;
	logic       is_text;
	logic       done;
	char_t      dch;

	always_comb begin
		if (!byte_value[7])
			lead_len = 3'd1;
		else if ((byte_value & MASK_2B) == LEAD_2B)
			lead_len = 3'd2;
		else if ((byte_value & MASK_3B) == LEAD_3B)
			lead_len = 3'd3;
		else if ((byte_value & MASK_4B) == LEAD_4B)
			lead_len = 3'd4;
		else
			lead_len = 3'd0;
	end

	always_comb begin
		br_n       = br_q;
		in_text_n  = in_text_q;
		partial_n  = partial_q;
		plen_n     = plen_q;
		cidx_n     = cidx_q;
		err_n      = err_q;
		push       = 1'b0;
		entry      = '{op: OP_REPORT, report: 1'b1, kind: K_MATCH, ch: '0};
		entry_cidx = cidx_q;
		is_text    = (mode == MODE_TEXT);
		done       = 1'b0;
		dch        = '0;
		case (mode)
			MODE_CLEAR: begin
				br_n      = '0;
				in_text_n = 1'b0;
				partial_n = '0;
				plen_n    = '0;
				cidx_n    = '0;
				err_n     = 1'b0;
				push      = 1'b1;
				entry.op  = OP_CLEAR;
			end
			MODE_END: begin
				br_n   = '0;
				cidx_n = '0;
				push   = 1'b1;
				if (err_q) begin
					entry.op     = OP_END;
					entry.report = 1'b0;
				end else if (br_q != 2'd0) begin
					entry.op   = OP_END;
					entry.kind = K_TRUNC;
					err_n      = 1'b1;
				end else if (plen_q == '0) begin
					entry.op   = OP_END;
					entry.kind = K_EMPTY;
					err_n      = 1'b1;
				end else begin
					entry.op = OP_JUDGE;
				end
			end
			default: begin
				if (!err_q) begin
					if (br_q != 2'd0 && in_text_q != is_text) begin
						// other stream still owes continuation bytes
						push       = 1'b1;
						entry.kind = K_TRUNC;
						err_n      = 1'b1;
					end else if (br_q == 2'd0) begin
						if (byte_value == CR_BYTE) begin
							done = 1'b0;
						end else if (lead_len == 3'd0) begin
							push       = 1'b1;
							entry.kind = K_BAD_LEAD;
							err_n      = 1'b1;
						end else if (lead_len == 3'd1) begin
							done = 1'b1;
							dch  = {3'd1, 24'd0, byte_value};
						end else begin
							partial_n = {lead_len, 24'd0, byte_value};
							br_n      = 2'(lead_len - 3'd1);
							in_text_n = is_text;
						end
					end else begin
						partial_n = {partial_q[34:32], partial_q[23:0], byte_value};
						br_n      = br_q - 2'd1;
						if (br_q == 2'd1) begin
							done = 1'b1;
							dch  = partial_n;
						end
					end
					if (done) begin
						push     = 1'b1;
						entry.ch = dch;
						if (!is_text) begin
							if (plen_q == PLW'(MAX_PATTERN_CHARS)) begin
								entry.kind = K_TOO_LONG;
								err_n      = 1'b1;
							end else begin
								entry.op = OP_PAT;
								plen_n   = plen_q + 1'b1;
							end
						end else if (cidx_q[POSITION_BITS]) begin
							entry.kind = K_TOO_LONG;
							err_n      = 1'b1;
						end else begin
							entry.op   = OP_TEXT;
							cidx_n     = cidx_q + 1'b1;
							entry_cidx = cidx_n;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q      <= '0;
			in_text_q <= 1'b0;
			partial_q <= '0;
			plen_q    <= '0;
			cidx_q    <= '0;
			err_q     <= 1'b0;
		end else if (accept) begin
			br_q      <= br_n;
			in_text_q <= in_text_n;
			partial_q <= partial_n;
			plen_q    <= plen_n;
			cidx_q    <= cidx_n;
			err_q     <= err_n;
		end
	end

endmodule

@@ design/u8seq_fifo.sv @@
// Small register queue between front and back end.
module u8seq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty,
	output logic             full
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == CW'(DEPTH));
	assign rdata     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/u8seq_back.sv @@
// Back end: pattern store, text window, parallel compare and result register.
module u8seq_back #(
	parameter int MAX_PATTERN_CHARS = 8,
	parameter int POSITION_BITS     = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  u8seq_pkg::entry_t        head,
	input  logic [POSITION_BITS:0]   head_cidx,
	output logic                     pop,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [2:0]               kind,
	output logic [POSITION_BITS-1:0] position
);
	import u8seq_pkg::*;

	localparam int M   = MAX_PATTERN_CHARS;
	localparam int PLW = $clog2(M + 1);

	// pattern held newest-first so lane j lines up with window lane j-1 (lane 0 with the incoming character)
	char_t                    pat_q [M];
	char_t                    win_q [M];
	logic [PLW-1:0]           plen_q;
	logic                     found_q;
	logic                     valid_q;
	kind_t                    kind_q;
	logic [POSITION_BITS-1:0] pos_q;

	logic                     hit;
	logic                     emit;
	kind_t                    emit_kind;
	logic [POSITION_BITS-1:0] emit_pos;

	assign pop = head_valid && (!valid_q || !result_stall);

	always_comb begin
		hit = (plen_q != '0) && (head_cidx >= (POSITION_BITS + 1)'(plen_q));
		if (head.ch != pat_q[0])
			hit = 1'b0;
		for (int j = 1; j < M; j++) begin
			if (j < int'(plen_q) && win_q[j-1] != pat_q[j])
				hit = 1'b0;
		end
	end

	always_comb begin
		emit      = 1'b0;
		emit_kind = head.kind;
		emit_pos  = '0;
		case (head.op)
			OP_TEXT: begin
				emit      = hit;
				emit_kind = K_MATCH;
				emit_pos  = POSITION_BITS'(head_cidx - (POSITION_BITS + 1)'(plen_q));
			end
			OP_JUDGE: begin
				emit      = 1'b1;
				emit_kind = found_q ? K_FOUND : K_NOT_FOUND;
			end
			OP_END:    emit = head.report;
			OP_REPORT: emit = 1'b1;
			default:   emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && head.op == OP_PAT) begin
			pat_q[0] <= head.ch;
			for (int j = 1; j < M; j++)
				pat_q[j] <= pat_q[j-1];
		end
		if (pop && head.op == OP_TEXT) begin
			win_q[0] <= head.ch;
			for (int j = 1; j < M; j++)
				win_q[j] <= win_q[j-1];
		end
		if (pop && emit) begin
			kind_q <= emit_kind;
			pos_q  <= emit_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= '0;
			found_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				case (head.op)
					OP_PAT:   plen_q  <= plen_q + 1'b1;
					OP_TEXT:  found_q <= found_q | hit;
					OP_JUDGE: found_q <= 1'b0;
					OP_END:   found_q <= 1'b0;
					OP_CLEAR: begin
						plen_q  <= '0;
						found_q <= 1'b0;
					end
					default:  found_q <= found_q;
				endcase
			end
			if (pop && emit)
				valid_q <= 1'b1;
			else if (!result_stall)
				valid_q <= 1'b0;
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign position     = pos_q;

endmodule

@@ design/utf8_character_sequence_search.sv @@
// Top level of the UTF-8 character sequence search.
//
//  beat      | signals                          | direction
//  ----------+----------------------------------+----------
//  byte      | byte_valid byte_stall mode       | in
//            | byte_value                       |
//  result    | result_valid result_stall kind   | out
//            | position                         |
//
// One byte beat per cycle sustained while byte_stall is low; a result passes
// through the queue slot and the result register after its beat.
// The four-entry queue holds up to four pending work items while the result side
// stalls (continuation and dropped bytes add none); byte_stall rises only when it is full.
// Reset clears all control state at once; no sweep is needed.
module utf8_character_sequence_search #(
	parameter int MAX_PATTERN_CHARS = 8,
	parameter int POSITION_BITS     = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_stall,
	input  logic [1:0]               mode,
	input  logic [7:0]               byte_value,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [2:0]               kind,
	output logic [POSITION_BITS-1:0] position
);
	import u8seq_pkg::*;

	localparam int QW    = $bits(entry_t) + POSITION_BITS + 1;
	localparam int QDEPTH = 4;

	logic                   accept;
	logic                   push;
	entry_t                 f_entry;
	logic [POSITION_BITS:0] f_cidx;
	logic [QW-1:0]          q_rdata;
	logic                   q_not_empty;
	logic                   q_full;
	logic                   pop;
	entry_t                 b_entry;
	logic [POSITION_BITS:0] b_cidx;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;

	u8seq_front #(
		.MAX_PATTERN_CHARS(MAX_PATTERN_CHARS),
		.POSITION_BITS    (POSITION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mode      (mode),
		.byte_value(byte_value),
		.push      (push),
		.entry     (f_entry),
		.entry_cidx(f_cidx)
	);

	u8seq_fifo #(
		.WIDTH(QW),
		.DEPTH(QDEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && push),
		.wdata    ({f_entry, f_cidx}),
		.pop      (pop),
		.rdata    (q_rdata),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	assign b_entry = entry_t'(q_rdata[QW-1:POSITION_BITS+1]);
	assign b_cidx  = q_rdata[POSITION_BITS:0];

	u8seq_back #(
		.MAX_PATTERN_CHARS(MAX_PATTERN_CHARS),
		.POSITION_BITS    (POSITION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_not_empty),
		.head        (b_entry),
		.head_cidx   (b_cidx),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind        (kind),
		.position    (position)
	);

endmodule

@@ design/u8seq_checker.sv @@
// Port-level checks for the UTF-8 character sequence search, bound to the top level.
module u8seq_checker #(
	parameter int POSITION_BITS = 20
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     byte_valid,
	input logic                     byte_stall,
	input logic                     result_valid,
	input logic                     result_stall,
	input logic [2:0]               kind,
	input logic [POSITION_BITS-1:0] position
);
	import u8seq_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(kind) && $stable(position))
		else $error("stalled result changed");

	// only a match carries a position
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != K_MATCH |-> position == '0)
		else $error("non-match result with nonzero position");

	// the queue fills only through an accepted beat
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(byte_stall) |-> $past(byte_valid))
		else $error("byte_stall rose without a beat offered");

endmodule

bind utf8_character_sequence_search u8seq_checker #(
	.POSITION_BITS(POSITION_BITS)
) u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.byte_valid  (byte_valid),
	.byte_stall  (byte_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.kind        (kind),
	.position    (position)
);
